// ===== rtl/dpb_pkg.sv =====
// dpb_pkg: shared types and constants of the depth pixel back-projection block
// holds payload structs, the configuration record and register index codes
// no dependencies
`default_nettype none

package dpb_pkg;

    // fixed field widths
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 16;
    localparam int INV_W    = 24;
    localparam int DIM_W    = 13;
    localparam int POS_W    = 32;
    localparam int Z_W      = 24;
    localparam int MAG_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // projection product split
    localparam int ZPROD_W = DEPTH_W + SCALE_W;     // depth times scale
    localparam int MZ_W    = MAG_W + Z_W;           // magnitude times z
    localparam int SPLIT_W = MZ_W / 2;              // low half of mag*z
    localparam int PART_W  = SPLIT_W + INV_W;       // one partial product
    localparam int PROD_W  = 64;
    localparam int FRAC_W  = 28;

    // small queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd6;

    // register reset values
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE  = 24'd16777;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5264;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3810;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd27540;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd27510;
    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic [SCALE_W-1:0]  depth_scale;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
    } t_cfg;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_raw;
        logic [COLOR_W-1:0] blue_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] red_in;
    } t_pixel;

    typedef struct packed {
        logic                    point_valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [Z_W-1:0]          pos_z;
        logic [COLOR_W-1:0]      blue_out;
        logic [COLOR_W-1:0]      green_out;
        logic [COLOR_W-1:0]      red_out;
        logic                    frame_end;
    } t_point;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               frame_end;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_x;
        logic               neg_y;
        logic [MAG_W-1:0]   mag_y;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/dpb_stream_if.sv =====
// dpb_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter, normally a struct from dpb_pkg
`default_nettype none

interface dpb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpb_front.sv =====
// dpb_front: accepts pixels, tracks column and row, classifies each pixel
// computes frame end and signed offsets from the principal point; uses dpb_pkg
`default_nettype none

module dpb_front #(
    parameter int MAX_FRAME_DIM = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dpb_pkg::t_cfg i_cfg,
    dpb_stream_if.sink         i_pixel,
    input  wire logic          i_full,
    output logic               o_push,
    output dpb_pkg::t_item     o_push_data
);
    import dpb_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_DIM);

    logic [CW-1:0]    r_col, r_row;
    logic [CW-1:0]    n_col, n_row;
    logic [DIM_W-1:0] eff_w, eff_h, last_w, last_h;
    logic [DIM_W-1:0] col_ext, row_ext;
    logic [MAG_W:0]   diff_x, diff_y;
    logic             accept;

    assign i_pixel.ready = !i_full;
    assign accept        = i_pixel.valid && !i_full;
    assign o_push        = accept;

    // clamp frame size to one through the maximum dimension
    always_comb begin
        eff_w = i_cfg.frame_width;
        if (i_cfg.frame_width == '0) begin
            eff_w = DIM_W'(1);
        end else if (i_cfg.frame_width > DIM_W'(MAX_FRAME_DIM)) begin
            eff_w = DIM_W'(MAX_FRAME_DIM);
        end
        eff_h = i_cfg.frame_height;
        if (i_cfg.frame_height == '0) begin
            eff_h = DIM_W'(1);
        end else if (i_cfg.frame_height > DIM_W'(MAX_FRAME_DIM)) begin
            eff_h = DIM_W'(MAX_FRAME_DIM);
        end
        last_w  = eff_w - DIM_W'(1);
        last_h  = eff_h - DIM_W'(1);
        col_ext = DIM_W'(r_col);
        row_ext = DIM_W'(r_row);
    end

    // raster counters advance on every accepted transaction
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_ext >= last_w) begin
            n_col = '0;
            n_row = (row_ext >= last_h) ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // offsets from the principal point in 1/16 pixel, as sign and magnitude
    always_comb begin
        diff_x = (MAG_W+1)'({r_col, 4'b0000}) - (MAG_W+1)'(i_cfg.center_x);
        diff_y = (MAG_W+1)'({r_row, 4'b0000}) - (MAG_W+1)'(i_cfg.center_y);
        o_push_data.depth     = i_pixel.data.depth_raw;
        o_push_data.blue      = i_pixel.data.blue_in;
        o_push_data.green     = i_pixel.data.green_in;
        o_push_data.red       = i_pixel.data.red_in;
        o_push_data.frame_end = (col_ext == last_w) && (row_ext == last_h);
        o_push_data.neg_x     = diff_x[MAG_W];
        o_push_data.mag_x     = diff_x[MAG_W] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
        o_push_data.neg_y     = diff_y[MAG_W];
        o_push_data.mag_y     = diff_y[MAG_W] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/dpb_queue.sv =====
// dpb_queue: short first-in first-out buffer between front and back
// holds classified pixels of type t_item from dpb_pkg
`default_nettype none

module dpb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dpb_pkg::t_item i_push_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output dpb_pkg::t_item      o_pop_data,
    output logic                o_empty
);
    import dpb_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dpb_back.sv =====
// dpb_back: multiply pipeline that turns classified pixels into 3-D points
// five stages plus an output register, all stalled together; uses dpb_pkg
`default_nettype none

module dpb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dpb_pkg::t_cfg  i_cfg,
    input  wire logic           i_empty,
    input  wire dpb_pkg::t_item i_item,
    output logic                o_pop,
    dpb_stream_if.source        o_point
);
    import dpb_pkg::*;

    // floor shift by the fraction width and saturate to signed 32 bits
    function automatic logic [POS_W-1:0] finish(input logic neg, input logic [PROD_W-1:0] prod);
        logic [PROD_W-FRAC_W:0] q;
        logic [PROD_W-FRAC_W:0] qn;
        logic [POS_W-1:0]       res;
        q  = (PROD_W-FRAC_W+1)'(prod[PROD_W-1:FRAC_W]);
        qn = q + (PROD_W-FRAC_W+1)'(prod[FRAC_W-1:0] != '0);
        if (!neg) begin
            res = (q > (PROD_W-FRAC_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[POS_W-1:0];
        end else if (qn > (PROD_W-FRAC_W+1)'(32'h8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = ~qn[POS_W-1:0] + 32'd1;
        end
        return res;
    endfunction

    logic en;
    logic [5:1] r_v;

    // per-stage payload
    t_item                r1_item;
    logic [ZPROD_W-1:0]   r1_zprod;
    logic                 r1_pv;

    t_item                r2_item;
    logic                 r2_pv;
    logic [Z_W-1:0]       r2_z;
    logic [MZ_W-1:0]      r2_mx, r2_my;

    t_item                r3_item;
    logic                 r3_pv;
    logic [Z_W-1:0]       r3_z;
    logic [PART_W-1:0]    r3_lo_x, r3_lo_y;
    logic [MZ_W-SPLIT_W-1:0] r3_hi_x, r3_hi_y;

    t_item                r4_item;
    logic                 r4_pv;
    logic [Z_W-1:0]       r4_z;
    logic [PART_W-1:0]    r4_lo_x, r4_lo_y;
    logic [PROD_W-SPLIT_W-1:0] r4_hp_x, r4_hp_y;

    t_item                r5_item;
    logic                 r5_pv;
    logic [Z_W-1:0]       r5_z;
    logic [PROD_W-1:0]    r5_px, r5_py;

    t_point               r_out;
    logic                 r_out_v;

    logic [ZPROD_W-9:0]   n_zs;
    logic [Z_W-1:0]       n_z;
    t_point               n_out;

    // whole pipeline moves when the output slot frees up
    assign en    = !r_out_v || o_point.ready;
    assign o_pop = en && !i_empty;

    assign o_point.valid = r_out_v;
    assign o_point.data  = r_out;

    // z scaling and saturation
    always_comb begin
        n_zs = r1_zprod[ZPROD_W-1:8];
        if (!r1_pv) begin
            n_z = '0;
        end else if (n_zs[ZPROD_W-9:Z_W] != '0) begin
            n_z = '1;
        end else begin
            n_z = n_zs[Z_W-1:0];
        end
    end

    // output formatting
    always_comb begin
        n_out.point_valid = r5_pv;
        n_out.pos_x       = finish(r5_item.neg_x, r5_px);
        n_out.pos_y       = finish(r5_item.neg_y, r5_py);
        n_out.pos_z       = r5_z;
        n_out.blue_out    = r5_item.blue;
        n_out.green_out   = r5_item.green;
        n_out.red_out     = r5_item.red;
        n_out.frame_end   = r5_item.frame_end;
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[4:1], !i_empty};
            r_out_v <= r_v[5];
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            // depth times scale
            r1_item  <= i_item;
            r1_pv    <= (i_item.depth != '0);
            r1_zprod <= i_item.depth * i_cfg.depth_scale;
            // magnitude times z
            r2_item  <= r1_item;
            r2_pv    <= r1_pv;
            r2_z     <= n_z;
            r2_mx    <= r1_item.mag_x * n_z;
            r2_my    <= r1_item.mag_y * n_z;
            // low partial product by the reciprocal
            r3_item  <= r2_item;
            r3_pv    <= r2_pv;
            r3_z     <= r2_z;
            r3_lo_x  <= r2_mx[SPLIT_W-1:0] * i_cfg.inv_focal_x;
            r3_lo_y  <= r2_my[SPLIT_W-1:0] * i_cfg.inv_focal_y;
            r3_hi_x  <= r2_mx[MZ_W-1:SPLIT_W];
            r3_hi_y  <= r2_my[MZ_W-1:SPLIT_W];
            // high partial product
            r4_item  <= r3_item;
            r4_pv    <= r3_pv;
            r4_z     <= r3_z;
            r4_lo_x  <= r3_lo_x;
            r4_lo_y  <= r3_lo_y;
            r4_hp_x  <= (PROD_W-SPLIT_W)'(r3_hi_x * i_cfg.inv_focal_x);
            r4_hp_y  <= (PROD_W-SPLIT_W)'(r3_hi_y * i_cfg.inv_focal_y);
            // combine partial products
            r5_item  <= r4_item;
            r5_pv    <= r4_pv;
            r5_z     <= r4_z;
            r5_px    <= {r4_hp_x, {SPLIT_W{1'b0}}} + PROD_W'(r4_lo_x);
            r5_py    <= {r4_hp_y, {SPLIT_W{1'b0}}} + PROD_W'(r4_lo_y);
            // result register
            r_out    <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/depth_pixel_backprojection_top.sv =====
// depth_pixel_backprojection_top: pinhole back-projection of depth pixels
// holds configuration registers, joins dpb_front, dpb_queue and dpb_back
//
// channel   direction  payload         transaction
// i_pixel   in         dpb_pkg::t_pixel valid && ready at rising edge
// o_point   out        dpb_pkg::t_point valid && ready at rising edge
// cfg       in         index + data    i_cfg_we at rising edge
//
// one pixel per cycle sustained while o_point is ready; a result passes from the queue
// through the five-stage multiply pipeline and the output register
// synchronous active-low reset clears counters, queue and valid bits; no clearing pass
// a stalled output freezes the pipeline; the 4-entry queue keeps taking pixels until full
`default_nettype none

module depth_pixel_backprojection_top #(
    parameter int MAX_FRAME_DIM = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dpb_stream_if.sink                             i_pixel,
    dpb_stream_if.source                           o_point
);
    import dpb_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, pop, empty;
    t_item push_data, pop_data;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_scale  <= RST_DEPTH_SCALE;
            r_cfg.center_x     <= RST_CENTER_X;
            r_cfg.center_y     <= RST_CENTER_Y;
            r_cfg.inv_focal_x  <= RST_INV_FOCAL_X;
            r_cfg.inv_focal_y  <= RST_INV_FOCAL_Y;
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEPTH_SCALE:  r_cfg.depth_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_CENTER_X:     r_cfg.center_x     <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:     r_cfg.center_y     <= i_cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:  r_cfg.inv_focal_x  <= i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:  r_cfg.inv_focal_y  <= i_cfg_data[INV_W-1:0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel intake and classification
    dpb_front #(
        .MAX_FRAME_DIM(MAX_FRAME_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pixel     (i_pixel),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decoupling queue
    dpb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // projection pipeline
    dpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_item  (pop_data),
        .o_pop   (pop),
        .o_point (o_point)
    );

endmodule

`default_nettype wire
